// ----- hw/rtl/zpnf_pkg.sv -----
// shared constants, types and the reciprocal table of the neighbour fill block
package zpnf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int PIX_W       = 8;
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int SUM_W       = 11;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int ROT_W       = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // result slots of one pixel step, in emission order
    localparam logic [1:0] SLOT_PREV_LEFT = 2'd0;
    localparam logic [1:0] SLOT_PREV_HERE = 2'd1;
    localparam logic [1:0] SLOT_CUR_LEFT  = 2'd2;
    localparam logic [1:0] SLOT_CUR_HERE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_FILL,
        ST_EMIT
    } zpnf_state_t;

    typedef struct packed {
        logic       accept;
        logic       load_win;
        logic       calc_sum;
        logic       calc_fill;
        logic       emit;
        logic [1:0] slot;
        logic       finish;
    } zpnf_cmd_t;

    typedef struct packed {
        logic [3:0] slot_mask;
        logic       out_free;
    } zpnf_status_t;

    // ceil(2^14 / n): exact floor division for sums below 2048, zero for n = 0
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 15'd16384;
            4'd2:    r = 15'd8192;
            4'd3:    r = 15'd5462;
            4'd4:    r = 15'd4096;
            4'd5:    r = 15'd3277;
            4'd6:    r = 15'd2731;
            4'd7:    r = 15'd2341;
            4'd8:    r = 15'd2048;
            default: r = 15'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/zpnf_ram.sv -----
// generic single write port, single read port ram with registered read
module zpnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/zpnf_ctrl.sv -----
// sequencing state machine of the neighbour fill block
module zpnf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  zpnf_pkg::zpnf_status_t status,
    output zpnf_pkg::zpnf_cmd_t    cmd
);

    import zpnf_pkg::*;

    zpnf_state_t state_reg;
    zpnf_state_t state_next;
    logic [1:0]  slot_reg;
    logic [1:0]  slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= SLOT_PREV_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        cmd         = '0;
        cmd.slot    = slot_reg;
        pixel_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_win = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.calc_fill = 1'b1;
                slot_next     = SLOT_PREV_LEFT;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                // skip empty slots, wait on a full output register
                if (!status.slot_mask[slot_reg] || status.out_free)
                begin
                    cmd.emit = status.slot_mask[slot_reg];
                    if (slot_reg == SLOT_CUR_HERE)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/zpnf_datapath.sv -----
// row stores, 3x3 window, neighbour mean and result register
module zpnf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [zpnf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [zpnf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 cfg_ready,
    input  logic [zpnf_pkg::PIX_W-1:0]           pixel,
    input  logic                                 result_ready,
    output logic                                 result_valid,
    output logic [zpnf_pkg::ROW_W-1:0]           out_row,
    output logic [zpnf_pkg::COL_W-1:0]           out_col,
    output logic [zpnf_pkg::PIX_W-1:0]           value,
    output logic                                 frame_end,
    input  zpnf_pkg::zpnf_cmd_t                  cmd,
    output zpnf_pkg::zpnf_status_t               status
);

    import zpnf_pkg::*;

    // configuration and position
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROT_W-1:0] rot_reg;

    // decode of the current position, latched at accept
    logic row_end_reg;
    logic last_row_reg;
    logic inner_reg;

    logic [FW_W-1:0] eff_w;
    logic [FH_W-1:0] eff_h;
    logic            row_end_now;
    logic            last_row_now;
    logic            inner_now;

    // window columns: 0 = c-2, 1 = c-1, 2 = c
    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] win_up_reg  [3];
    logic [PIX_W-1:0] win_mid_reg [3];
    logic [PIX_W-1:0] win_in_reg  [3];

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PIX_W-1:0] fill_reg;

    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  fill_next;
    logic              fill_wr;

    logic              result_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [PIX_W-1:0]  value_reg;
    logic              frame_end_reg;

    // row store rotation
    logic [2:0]       is_in;
    logic [2:0]       is_mid;
    logic [2:0]       is_up;
    logic [2:0]       ram_we;
    logic [COL_W-1:0] ram_waddr [3];
    logic [PIX_W-1:0] ram_wdata [3];
    logic [PIX_W-1:0] ram_rdata [3];
    logic [PIX_W-1:0] up_rdata;
    logic [PIX_W-1:0] mid_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = FW_W'(1);
        end
        else if (width_reg > FW_W'(MAX_WIDTH))
        begin
            eff_w = FW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? FH_W'(1) : height_reg;
    end

    assign row_end_now  = FW_W'(col_reg) >= (eff_w - FW_W'(1));
    assign last_row_now = row_reg >= (eff_h - FH_W'(1));
    assign inner_now    = (row_reg >= ROW_W'(2))
                       && ((17'(row_reg) + 17'd1) <= 17'(eff_h))
                       && (col_reg >= COL_W'(2))
                       && ((FW_W'(col_reg) + FW_W'(1)) <= eff_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= FW_W'(1024);
            height_reg   <= FH_W'(1024);
            row_reg      <= '0;
            col_reg      <= '0;
            rot_reg      <= '0;
            row_end_reg  <= 1'b0;
            last_row_reg <= 1'b0;
            inner_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.accept)
            begin
                row_end_reg  <= row_end_now;
                last_row_reg <= last_row_now;
                inner_reg    <= inner_now;
            end
            if (cmd.finish)
            begin
                if (row_end_reg)
                begin
                    col_reg <= '0;
                    row_reg <= last_row_reg ? '0 : row_reg + ROW_W'(1);
                    rot_reg <= (rot_reg == ROT_W'(2)) ? '0 : rot_reg + ROT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // neighbour sum and count of nonzero neighbours
    always_comb
    begin
        logic [PIX_W-1:0] nb [8];
        nb[0] = win_up_reg[0];
        nb[1] = win_up_reg[1];
        nb[2] = win_up_reg[2];
        nb[3] = win_mid_reg[0];
        nb[4] = win_mid_reg[2];
        nb[5] = win_in_reg[0];
        nb[6] = win_in_reg[1];
        nb[7] = win_in_reg[2];
        sum_next = '0;
        cnt_next = '0;
        for (int k = 0; k < 8; k++)
        begin
            sum_next = sum_next + SUM_W'(nb[k]);
            cnt_next = cnt_next + CNT_W'(nb[k] != '0);
        end
    end

    // floor(sum / count) by reciprocal; a zero count gives zero
    assign prod      = PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));
    assign fill_wr   = inner_reg && (win_mid_reg[1] == '0);
    assign fill_next = fill_wr ? prod[RECIP_SHIFT +: PIX_W] : win_mid_reg[1];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg <= pixel;
        end
        if (cmd.load_win)
        begin
            win_up_reg[0]  <= win_up_reg[1];
            win_up_reg[1]  <= win_up_reg[2];
            win_up_reg[2]  <= up_rdata;
            win_mid_reg[0] <= win_mid_reg[1];
            win_mid_reg[1] <= win_mid_reg[2];
            win_mid_reg[2] <= mid_rdata;
            win_in_reg[0]  <= win_in_reg[1];
            win_in_reg[1]  <= win_in_reg[2];
            win_in_reg[2]  <= pixel_reg;
        end
        if (cmd.calc_sum)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (cmd.calc_fill)
        begin
            fill_reg       <= fill_next;
            win_mid_reg[1] <= fill_next;
        end
    end

    // three physical stores, roles rotate at each row end
    for (genvar j = 0; j < 3; j++)
    begin : g_row_store
        assign is_in[j]  = rot_reg == ROT_W'(j);
        assign is_mid[j] = rot_reg == ROT_W'((j + 1) % 3);
        assign is_up[j]  = rot_reg == ROT_W'((j + 2) % 3);

        assign ram_we[j]    = (cmd.accept && is_in[j]) || (cmd.calc_fill && fill_wr && is_mid[j]);
        assign ram_waddr[j] = is_mid[j] ? col_reg - COL_W'(1) : col_reg;
        assign ram_wdata[j] = is_mid[j] ? fill_next : pixel;

        zpnf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[j]),
            .waddr (ram_waddr[j]),
            .wdata (ram_wdata[j]),
            .raddr (col_reg),
            .rdata (ram_rdata[j])
        );
    end

    always_comb
    begin
        up_rdata  = '0;
        mid_rdata = '0;
        for (int j = 0; j < 3; j++)
        begin
            up_rdata  = up_rdata  | (ram_rdata[j] & {PIX_W{is_up[j]}});
            mid_rdata = mid_rdata | (ram_rdata[j] & {PIX_W{is_mid[j]}});
        end
    end

    // result slots present for this step
    assign status.slot_mask[SLOT_PREV_LEFT] = (row_reg != '0) && (col_reg != '0);
    assign status.slot_mask[SLOT_PREV_HERE] = (row_reg != '0) && row_end_reg;
    assign status.slot_mask[SLOT_CUR_LEFT]  = last_row_reg && (col_reg != '0);
    assign status.slot_mask[SLOT_CUR_HERE]  = last_row_reg && row_end_reg;
    assign status.out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            unique case (cmd.slot)
                SLOT_PREV_LEFT:
                begin
                    out_row_reg   <= row_reg - ROW_W'(1);
                    out_col_reg   <= col_reg - COL_W'(1);
                    value_reg     <= fill_reg;
                    frame_end_reg <= 1'b0;
                end
                SLOT_PREV_HERE:
                begin
                    out_row_reg   <= row_reg - ROW_W'(1);
                    out_col_reg   <= col_reg;
                    value_reg     <= win_mid_reg[2];
                    frame_end_reg <= 1'b0;
                end
                SLOT_CUR_LEFT:
                begin
                    out_row_reg   <= row_reg;
                    out_col_reg   <= col_reg - COL_W'(1);
                    value_reg     <= win_in_reg[1];
                    frame_end_reg <= 1'b0;
                end
                SLOT_CUR_HERE:
                begin
                    out_row_reg   <= row_reg;
                    out_col_reg   <= col_reg;
                    value_reg     <= win_in_reg[2];
                    frame_end_reg <= 1'b1;
                end
                default:
                begin
                    frame_end_reg <= 1'b0;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign value        = value_reg;
    assign frame_end    = frame_end_reg;

endmodule

// ----- hw/rtl/zero_pixel_neighbour_fill.sv -----
// top level of the 3x3 neighbour-mean fill of empty pixels
//
// takes a raster-order 8-bit grayscale frame, one pixel per transfer, and returns every
// pixel with its row and column; an interior zero pixel is replaced by the floor of the
// mean of its nonzero 8 neighbours (zero if all are zero), filling in place so the upper
// and left neighbours are already filled values; border pixels and nonzero pixels pass
// through; a pixel's result leaves once the pixel to its lower right has arrived (border
// pixels as soon as possible) and the last result of a frame has frame_end set; each
// accepted pixel gives 0 to 4 results and passes through transfer, window load from the
// row stores, neighbour sum, reciprocal divide, then four result slots through the output
// register, which is where a stalled result channel holds it up; the next pixel is taken
// while the last result still waits; frame_width and frame_height are written on the
// config port (index 0 and 1) between frames; three 1024 x 8 row stores rotate roles at
// each row end and need no clearing
module zero_pixel_neighbour_fill (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [zpnf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [zpnf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel stream in
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [zpnf_pkg::PIX_W-1:0]       pixel,
    // result stream out
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [zpnf_pkg::ROW_W-1:0]       out_row,
    output logic [zpnf_pkg::COL_W-1:0]       out_col,
    output logic [zpnf_pkg::PIX_W-1:0]       value,
    output logic                             frame_end
);

    import zpnf_pkg::*;

    // commands from the sequencer, status back from the datapath
    zpnf_cmd_t    cmd;
    zpnf_status_t status;

    zpnf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // row stores, sliding window, mean unit and result register
    zpnf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg_ready    (cfg_ready),
        .pixel        (pixel),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .value        (value),
        .frame_end    (frame_end),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
